/* hw/rtl/ntc_pkg.sv */
package ntc_pkg;

  localparam int unsigned MAX_ADC_BITS = 16;
  localparam int unsigned RAW_W        = 16;
  localparam int unsigned BITS_W       = 5;

  // log2 unit: product width, exponent width, fraction bits
  localparam int unsigned PROD_W  = 40;
  localparam int unsigned EXP_W   = 6;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned MANT_W  = 31;
  localparam int unsigned LN_W    = 29;

  // divider: quotient bits and remainder width
  localparam int unsigned QUO_W   = 28;
  localparam int unsigned REM_W   = 48;

  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [19:0] RECIP_C    = 20'd671089;   // ceil(2^26/100)
  localparam logic [23:0] RECIP_F    = 24'd8589935;  // ceil(2^33/1000)
  localparam logic [36:0] ZERO_C_OFS = 37'd1790115840; // 27315 * 65536
  localparam logic [40:0] F_OFS      = 41'd1048576000;

  // pipeline stage map
  localparam int unsigned STG_PRE   = 0;
  localparam int unsigned STG_PROD  = 1;
  localparam int unsigned STG_NORM  = 2;
  localparam int unsigned STG_LN    = STG_NORM + FRAC_W + 1;
  localparam int unsigned STG_DIFF  = STG_LN + 1;
  localparam int unsigned STG_DEN   = STG_DIFF + 1;
  localparam int unsigned STG_DINIT = STG_DEN + 1;
  localparam int unsigned STG_KQ    = STG_DINIT + QUO_W + 1;
  localparam int unsigned STG_CV    = STG_KQ + 1;
  localparam int unsigned STG_ABS   = STG_CV + 1;
  localparam int unsigned STG_RCP   = STG_ABS + 1;
  localparam int unsigned NSTG      = STG_RCP + 1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StRail  = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    UnitC    = 2'd0,
    UnitF    = 2'd1,
    UnitK    = 2'd2,
    UnitNone = 2'd3
  } unit_e;

  typedef enum logic [2:0] {
    RegSupply  = 3'd0,
    RegSeries  = 3'd1,
    RegAdcBits = 3'd2,
    RegBeta    = 3'd3,
    RegNominal = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    unit_e   unit;
    status_e st;
    logic    byp;
  } tag_t;

endpackage

/* hw/rtl/ntc_adc_to_temperature.sv */
// channel   dir  beat contents (low bits first)
// s_axis    in   tdata: raw_sample[15:0]      tuser: func[1:0]
// m_axis    out  tdata: temperature[15:0]     tuser: status[1:0]
// apb       in   five config registers at byte offsets 0,4,8,12,16
//
// one sample per cycle while the output skid slot is empty; the pipeline
// depth is set by the 24 squaring steps of the two log2 units and the
// 28 restoring steps of the kelvin divider, one step per stage
// reset clears the config registers to their defaults and all valid bits
// the whole pipeline holds while the output skid slot is occupied, so an
// input beat is still taken while one finished result waits downstream
module ntc_adc_to_temperature (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // raw_sample[15:0]
  input  logic [1:0]  s_axis_tuser_i,   // func[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // temperature[15:0]
  output logic [1:0]  m_axis_tuser_o,   // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ntc_pkg::*;

  // ---------------- config registers ----------------
  logic [12:0] supply_q;
  logic [23:0] series_q;
  logic [4:0]  adc_bits_q;
  logic [15:0] beta_q;
  logic [23:0] nominal_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q   <= 13'd3300;
      series_q   <= 24'd10000;
      adc_bits_q <= 5'd12;
      beta_q     <= 16'd3950;
      nominal_q  <= 24'd10000;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSupply:  supply_q   <= pwdata[12:0];
        RegSeries:  series_q   <= pwdata[23:0];
        RegAdcBits: adc_bits_q <= pwdata[4:0];
        RegBeta:    beta_q     <= pwdata[15:0];
        RegNominal: nominal_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      RegSupply:  prdata = {19'd0, supply_q};
      RegSeries:  prdata = {8'd0, series_q};
      RegAdcBits: prdata = {27'd0, adc_bits_q};
      RegBeta:    prdata = {16'd0, beta_q};
      RegNominal: prdata = {8'd0, nominal_q};
      default:    prdata = 32'd0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic            en;
  logic            skid_q;
  logic [NSTG-1:0] v_q;
  tag_t            tag_q [NSTG];
  tag_t            tag_pre;
  tag_t            tag_kq;

  assign en              = ~skid_q;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NSTG; i++) begin
        if (i == STG_PRE) begin
          tag_q[i] <= tag_pre;
        end else if (i == STG_KQ) begin
          tag_q[i] <= tag_kq;
        end else begin
          tag_q[i] <= tag_q[i-1];
        end
      end
    end
  end

  // ---------------- stage: clamp and rail checks ----------------
  logic [BITS_W-1:0] bits;
  logic [RAW_W-1:0]  fs;
  logic [RAW_W-1:0]  raw_in;
  logic [RAW_W-1:0]  raw_c;
  logic              over;
  logic              zero_reg;
  logic [RAW_W-1:0]  raw_q;
  logic [RAW_W-1:0]  dif_q;

  always_comb begin
    if (adc_bits_q == '0) begin
      bits = BITS_W'(1);
    end else if (adc_bits_q > BITS_W'(MAX_ADC_BITS)) begin
      bits = BITS_W'(MAX_ADC_BITS);
    end else begin
      bits = adc_bits_q;
    end
    fs       = RAW_W'(({{RAW_W{1'b0}}, 1'b1} << bits) - {{RAW_W{1'b0}}, 1'b1});
    raw_in   = s_axis_tdata_i;
    over     = raw_in > fs;
    raw_c    = over ? fs : raw_in;
    zero_reg = (series_q == '0) | (nominal_q == '0) | (beta_q == '0);
    tag_pre.unit = unit_e'(s_axis_tuser_i);
    if (over || zero_reg) begin
      tag_pre.st = StRange;
    end else if (raw_c == '0 || raw_c == fs) begin
      tag_pre.st = StRail;
    end else begin
      tag_pre.st = StOk;
    end
    tag_pre.byp = (tag_pre.st != StOk);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      raw_q <= raw_c;
      dif_q <= fs - raw_c;
    end
  end

  // ---------------- stage: divider products ----------------
  // index 0 is series*raw, index 1 is nominal*(fs-raw)
  logic [PROD_W-1:0] prod_q [2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q[0] <= series_q * raw_q;
      prod_q[1] <= nominal_q * dif_q;
    end
  end

  // ---------------- stage: normalize, then 24 squaring steps ----------------
  logic [EXP_W-1:0]  lod   [2];
  logic [PROD_W-1:0] shl   [2];
  logic [MANT_W-1:0] m_q   [FRAC_W+1][2];
  logic [FRAC_W-1:0] fr_q  [FRAC_W+1][2];
  logic [EXP_W-1:0]  e_q   [FRAC_W+1][2];
  logic [2*MANT_W-1:0] sq  [FRAC_W][2];

  always_comb begin
    for (int u = 0; u < 2; u++) begin
      lod[u] = '0;
      for (int b = 0; b < PROD_W; b++) begin
        if (prod_q[u][b]) lod[u] = EXP_W'(b);
      end
      shl[u] = prod_q[u] << (EXP_W'(PROD_W - 1) - lod[u]);
    end
    for (int k = 0; k < FRAC_W; k++) begin
      for (int u = 0; u < 2; u++) begin
        sq[k][u] = m_q[k][u] * m_q[k][u];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int u = 0; u < 2; u++) begin
        m_q[0][u]  <= shl[u][PROD_W-1 -: MANT_W];
        fr_q[0][u] <= '0;
        e_q[0][u]  <= lod[u];
        for (int k = 0; k < FRAC_W; k++) begin
          e_q[k+1][u] <= e_q[k][u];
          if (sq[k][u][61]) begin
            m_q[k+1][u]  <= sq[k][u][61:31];
            fr_q[k+1][u] <= {fr_q[k][u][FRAC_W-2:0], 1'b1};
          end else begin
            m_q[k+1][u]  <= sq[k][u][60:30];
            fr_q[k+1][u] <= {fr_q[k][u][FRAC_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // ---------------- stage: ln from log2 ----------------
  logic [LN_W-1:0] ln_q [2];
  logic [62:0]     lnp  [2];

  always_comb begin
    for (int u = 0; u < 2; u++) begin
      lnp[u] = 63'({e_q[FRAC_W][u], fr_q[FRAC_W][u]} * LN2_Q32) + 63'(64'h8000_0000);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int u = 0; u < 2; u++) begin
        ln_q[u] <= lnp[u][32 +: LN_W];
      end
    end
  end

  // ---------------- stage: log ratio, then beta denominator ----------------
  logic signed [LN_W:0]   l_q;
  logic signed [45:0]     lm;
  logic [22:0]            b100;
  logic signed [48:0]     d_q;

  assign lm   = l_q * 16'sd29815;
  assign b100 = 23'(beta_q * 7'd100);

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_q <= $signed({1'b0, ln_q[0]}) - $signed({1'b0, ln_q[1]});
      d_q <= $signed({2'b00, b100, 24'd0}) + $signed({{3{lm[45]}}, lm});
    end
  end

  // ---------------- kelvin divider: N*2^40 / d, one bit a stage ----------------
  logic [30:0]        nn;
  logic [REM_W-1:0]   r0;
  logic               dpos;
  logic [REM_W-1:0]   r_q   [QUO_W+1];
  logic [REM_W-1:0]   dd_q  [QUO_W+1];
  logic [QUO_W-1:0]   q_q   [QUO_W+1];
  logic               sat_q [QUO_W+1];
  logic [REM_W:0]     dtr   [QUO_W];

  assign nn   = 31'(beta_q * 15'd29815);
  assign r0   = {5'd0, nn, 12'd0};
  assign dpos = ~d_q[48] & (d_q != '0);

  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      dtr[k] = {r_q[k], 1'b0} - {1'b0, dd_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q[0]   <= r0;
      dd_q[0]  <= d_q[REM_W-1:0];
      q_q[0]   <= '0;
      sat_q[0] <= ~dpos | ({1'b0, r0} >= d_q[REM_W:0]);
      for (int k = 0; k < QUO_W; k++) begin
        dd_q[k+1]  <= dd_q[k];
        sat_q[k+1] <= sat_q[k];
        if (!dtr[k][REM_W]) begin
          r_q[k+1] <= dtr[k][REM_W-1:0];
          q_q[k+1] <= {q_q[k][QUO_W-2:0], 1'b1};
        end else begin
          r_q[k+1] <= {r_q[k][REM_W-2:0], 1'b0};
          q_q[k+1] <= {q_q[k][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------- stage: kelvin select ----------------
  logic [QUO_W-1:0] kq_q;
  tag_t             tag_div;

  assign tag_div = tag_q[STG_KQ-1];

  always_comb begin
    tag_kq = tag_div;
    if (!tag_div.byp && sat_q[QUO_W]) tag_kq.st = StRange;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tag_div.byp) begin
        kq_q <= '0;
      end else if (sat_q[QUO_W]) begin
        kq_q <= '1;
      end else begin
        kq_q <= q_q[QUO_W];
      end
    end
  end

  // ---------------- unit conversion stages ----------------
  logic signed [36:0] c_d;
  logic signed [36:0] c_q;
  logic signed [40:0] f_q;
  logic [11:0]        k_q [3];
  logic [36:0]        c_abs;
  logic [40:0]        f_abs;
  logic               nc_q  [2];
  logic               nf_q  [2];
  logic [18:0]        xc_q;
  logic [22:0]        xf_q;
  logic [12:0]        qc_q;
  logic [13:0]        qf_q;
  logic [38:0]        pc;
  logic [46:0]        pf;

  assign c_d   = $signed(37'(kq_q * 7'd100) - ZERO_C_OFS);
  assign c_abs = c_q[36] ? 37'(-c_q) : c_q;
  assign f_abs = f_q[40] ? 41'(-f_q) : f_q;
  assign pc    = xc_q * RECIP_C;
  assign pf    = xf_q * RECIP_F;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q     <= c_d;
      f_q     <= 41'(c_d * 41'sd9) + $signed(F_OFS);
      k_q[0]  <= kq_q[QUO_W-1 -: 12];
      xc_q    <= c_abs[34:16];
      xf_q    <= f_abs[37:15];
      nc_q[0] <= c_q[36];
      nf_q[0] <= f_q[40];
      k_q[1]  <= k_q[0];
      qc_q    <= pc[38:26];
      qf_q    <= pf[46:33];
      nc_q[1] <= nc_q[0];
      nf_q[1] <= nf_q[0];
      k_q[2]  <= k_q[1];
    end
  end

  logic [15:0] t_fin;
  logic [15:0] tc;
  logic [15:0] tf;
  tag_t        tag_last;

  assign tag_last = tag_q[NSTG-1];
  assign tc = nc_q[1] ? 16'(-{3'd0, qc_q}) : {3'd0, qc_q};
  assign tf = nf_q[1] ? 16'(-{2'd0, qf_q}) : {2'd0, qf_q};

  always_comb begin
    case (tag_last.unit)
      UnitC:   t_fin = tc;
      UnitF:   t_fin = tf;
      UnitK:   t_fin = {4'd0, k_q[2]};
      default: t_fin = '0;
    endcase
  end

  // ---------------- output register and skid slot ----------------
  logic        out_v_q;
  logic [15:0] out_t_q;
  logic [1:0]  out_s_q;
  logic [15:0] skid_t_q;
  logic [1:0]  skid_s_q;
  logic        pop;

  assign pop = out_v_q & m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_q  <= 1'b0;
    end else if (skid_q) begin
      if (pop) skid_q <= 1'b0;
    end else if (v_q[NSTG-1]) begin
      if (!out_v_q || pop) begin
        out_v_q <= 1'b1;
      end else begin
        skid_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_q) begin
      if (pop) begin
        out_t_q <= skid_t_q;
        out_s_q <= skid_s_q;
      end
    end else if (v_q[NSTG-1]) begin
      if (!out_v_q || pop) begin
        out_t_q <= t_fin;
        out_s_q <= tag_last.st;
      end else begin
        skid_t_q <= t_fin;
        skid_s_q <= tag_last.st;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_t_q;
  assign m_axis_tuser_o  = out_s_q;

  // ---------------- checks ----------------
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_v_q) else $error("skid slot full with empty output");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_s_q != 2'd3)) else $error("bad status code");

  a_skid_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(skid_q) |-> $past(pop)) else $error("skid beat dropped");

endmodule
